@@ hw/rtl/tlfr_pkg.sv @@
// ----------------------------------------------------------------------------
// tlfr_pkg
// shared types and constants of the two-level frame reorder block
// ----------------------------------------------------------------------------
package tlfr_pkg;

  // frame types that go through the header level
  localparam logic [7:0] TYPE_HDR_A = 8'h01;
  localparam logic [7:0] TYPE_HDR_B = 8'h09;
  localparam logic [7:0] TYPE_HDR_C = 8'h05;

  // result codes
  localparam logic [1:0] OUT_DELIVER = 2'd0;
  localparam logic [1:0] OUT_DUP     = 2'd1;
  localparam logic [1:0] OUT_BEYOND  = 2'd2;
  localparam logic [1:0] OUT_NO_SLOT = 2'd3;

  // results reported per input item, count width holds the cap itself
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 7;

  // work handed from the header level to the stream level
  typedef struct packed {
    logic        drop;    // header-level drop, report only
    logic [1:0]  code;
    logic [15:0] tag;
    logic [30:0] stream;
    logic [31:0] fseq;
    logic        eoi;     // last job of its input item
  } job_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [15:0] tag;
    logic [30:0] stream;
    logic [31:0] seq;
    logic        last;
  } res_t;

endpackage

@@ hw/rtl/tlfr_fifo.sv @@
// ----------------------------------------------------------------------------
// tlfr_fifo
// small flop-based first-in first-out queue
// ----------------------------------------------------------------------------
module tlfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/tlfr_front.sv @@
// ----------------------------------------------------------------------------
// tlfr_front
// header level: accepts frames, orders header-class frames by header sequence
// ----------------------------------------------------------------------------
module tlfr_front #(
  parameter int HEADER_WINDOW = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        frame_type_i,
  input  logic [31:0]       header_seq_i,
  input  logic [31:0]       frame_seq_i,
  input  logic [30:0]       stream_ident_i,
  input  logic [15:0]       frame_tag_i,
  output logic              q_push_o,
  output tlfr_pkg::job_t    q_job_o,
  input  logic              q_full_i
);

  localparam int HW = HEADER_WINDOW;
  localparam int KW = (HW > 1) ? $clog2(HW) : 1;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_CASC = 1'b1;

  logic          state_q, state_d;
  logic [31:0]   exp_q, exp_d;
  logic [HW-1:0] hfull_q, hfull_d;
  logic [15:0]   htag_q  [HW];
  logic [30:0]   hstr_q  [HW];
  logic [31:0]   hfseq_q [HW];

  logic          accept, is_hdr, in_win, store;
  logic [31:0]   ahead, dm1;
  logic [KW-1:0] k;
  logic [1:0]    shift_n;
  logic [HW:0]   full_ext;
  logic [HW+1:0] full_pad;

  assign full_o   = (state_q == F_CASC) | q_full_i;
  assign accept   = push_i & ~full_o;
  assign is_hdr   = (frame_type_i == tlfr_pkg::TYPE_HDR_A) ||
                    (frame_type_i == tlfr_pkg::TYPE_HDR_B) ||
                    (frame_type_i == tlfr_pkg::TYPE_HDR_C);
  assign ahead    = header_seq_i - exp_q;
  assign dm1      = ahead - 32'd1;
  assign k        = dm1[KW-1:0];
  assign in_win   = (ahead <= 32'(HW));
  assign full_ext = {1'b0, hfull_q};
  assign full_pad = {2'b00, hfull_q};

  always_comb begin
    state_d        = state_q;
    shift_n        = 2'd0;
    store          = 1'b0;
    q_push_o       = 1'b0;
    q_job_o.drop   = 1'b0;
    q_job_o.code   = tlfr_pkg::OUT_DELIVER;
    q_job_o.tag    = frame_tag_i;
    q_job_o.stream = stream_ident_i;
    q_job_o.fseq   = frame_seq_i;
    q_job_o.eoi    = 1'b1;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (!is_hdr) begin
            q_push_o = 1'b1;
          end else if (header_seq_i < exp_q) begin
            q_push_o     = 1'b1;
            q_job_o.drop = 1'b1;
            q_job_o.code = tlfr_pkg::OUT_DUP;
          end else if (header_seq_i == exp_q) begin
            q_push_o    = 1'b1;
            q_job_o.eoi = ~hfull_q[0];
            if (hfull_q[0]) begin
              state_d = F_CASC;
            end else begin
              shift_n = 2'd1;
            end
          end else if (in_win) begin
            if (hfull_q[k]) begin
              q_push_o     = 1'b1;
              q_job_o.drop = 1'b1;
              q_job_o.code = tlfr_pkg::OUT_DUP;
            end else begin
              store = 1'b1;
            end
          end else begin
            q_push_o     = 1'b1;
            q_job_o.drop = 1'b1;
            q_job_o.code = tlfr_pkg::OUT_BEYOND;
          end
        end
      end
      F_CASC: begin
        // release the head slot, then skip the empty one that ends the run
        q_job_o.tag    = htag_q[0];
        q_job_o.stream = hstr_q[0];
        q_job_o.fseq   = hfseq_q[0];
        q_job_o.eoi    = ~full_ext[1];
        if (!q_full_i) begin
          q_push_o = 1'b1;
          if (full_ext[1]) begin
            shift_n = 2'd1;
          end else begin
            shift_n = 2'd2;
            state_d = F_IDLE;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
    exp_d   = exp_q + 32'(shift_n);
    hfull_d = HW'(full_pad >> shift_n);
    if (store) begin
      hfull_d[k] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      exp_q   <= 32'd1;
      hfull_q <= '0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      hfull_q <= hfull_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HW; i++) begin
      if (shift_n == 2'd1 && i + 1 < HW) begin
        htag_q[i]  <= htag_q[(i + 1 < HW) ? i + 1 : i];
        hstr_q[i]  <= hstr_q[(i + 1 < HW) ? i + 1 : i];
        hfseq_q[i] <= hfseq_q[(i + 1 < HW) ? i + 1 : i];
      end else if (shift_n == 2'd2 && i + 2 < HW) begin
        htag_q[i]  <= htag_q[(i + 2 < HW) ? i + 2 : i];
        hstr_q[i]  <= hstr_q[(i + 2 < HW) ? i + 2 : i];
        hfseq_q[i] <= hfseq_q[(i + 2 < HW) ? i + 2 : i];
      end
    end
    if (store) begin
      htag_q[k]  <= frame_tag_i;
      hstr_q[k]  <= stream_ident_i;
      hfseq_q[k] <= frame_seq_i;
    end
  end

endmodule

@@ hw/rtl/tlfr_back.sv @@
// ----------------------------------------------------------------------------
// tlfr_back
// stream level: stream table lookup, per-stream window and in-order release
// ----------------------------------------------------------------------------
module tlfr_back #(
  parameter int STREAM_WINDOW = 8,
  parameter int STREAM_SLOTS  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  tlfr_pkg::job_t  q_job_i,
  output logic            q_pop_o,
  input  logic            o_full_i,
  output logic            o_push_o,
  output tlfr_pkg::res_t  o_res_o
);

  localparam int SW  = STREAM_WINDOW;
  localparam int NS  = STREAM_SLOTS;
  localparam int HPW = (SW > 1) ? $clog2(SW) : 1;
  localparam int SIW = (NS > 1) ? $clog2(NS) : 1;
  localparam int MD  = NS * SW;
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int CW  = tlfr_pkg::CNT_W;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_DROP  = 3'd1;
  localparam logic [2:0] B_MATCH = 3'd2;
  localparam logic [2:0] B_LOOK  = 3'd3;
  localparam logic [2:0] B_DEC   = 3'd4;
  localparam logic [2:0] B_DRAIN = 3'd5;
  localparam logic [2:0] B_EMIT  = 3'd6;
  localparam logic [2:0] B_FIN   = 3'd7;

  logic [2:0]     state_q, state_d;
  tlfr_pkg::job_t job_q;
  logic [SIW-1:0] s_q, s_d;
  logic [NS-1:0]  in_use_q, hit_q;
  logic [30:0]    key_q  [NS];
  logic [31:0]    exp_q  [NS];
  logic [SW-1:0]  sfull_q[NS];
  logic [HPW-1:0] head_q [NS];
  logic [15:0]    tag_mem[MD];
  logic [15:0]    rdata_q;
  logic [31:0]    e_q, e_d;
  tlfr_pkg::res_t pend_q;
  logic           pend_v_q;
  logic [CW-1:0]  cnt_q;

  // lookup
  logic           hit_any, free_any, alloc;
  logic [SIW-1:0] hit_idx, free_idx;
  // decision
  logic [31:0]    e_cur, ahead, dm1;
  logic [HPW-1:0] k;
  logic           in_win, set_bit, drain_take, drain_step, drain_done;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_wa, mem_ra;
  // emission
  logic           emit_req, can_emit, fire, keep, fin_push;
  logic [1:0]     emit_code;
  logic [15:0]    emit_tag;
  logic [31:0]    emit_seq;
  logic [2:0]     job_end;

  function automatic logic [AW-1:0] phys(logic [SIW-1:0] s, logic [HPW-1:0] h,
                                         logic [HPW-1:0] kk);
    logic [HPW:0] off;
    off = {1'b0, h} + {1'b0, kk};
    if (off >= (HPW + 1)'(SW)) begin
      off = off - (HPW + 1)'(SW);
    end
    return AW'(s) * AW'(SW) + AW'(off);
  endfunction

  function automatic logic [HPW-1:0] head_inc(logic [HPW-1:0] h);
    logic [HPW:0] n;
    n = {1'b0, h} + (HPW + 1)'(1);
    if (n == (HPW + 1)'(SW)) begin
      n = '0;
    end
    return n[HPW-1:0];
  endfunction

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NS; i++) begin
      if (!hit_any && hit_q[i]) begin
        hit_any = 1'b1;
        hit_idx = SIW'(i);
      end
      if (!free_any && !in_use_q[i]) begin
        free_any = 1'b1;
        free_idx = SIW'(i);
      end
    end
  end

  assign e_cur    = exp_q[s_q];
  assign ahead    = job_q.fseq - e_cur;
  assign dm1      = ahead - 32'd1;
  assign k        = dm1[HPW-1:0];
  assign in_win   = (ahead <= 32'(SW));
  assign can_emit = ~pend_v_q | ~o_full_i;
  assign fire     = emit_req & can_emit;
  assign keep     = fire & ~cnt_q[CW-1];
  assign job_end  = job_q.eoi ? B_FIN : B_IDLE;
  assign mem_wa   = phys(s_q, head_q[s_q], k);
  assign mem_ra   = phys(s_q, head_q[s_q], '0);

  always_comb begin
    state_d    = state_q;
    s_d        = s_q;
    e_d        = e_q;
    q_pop_o    = 1'b0;
    alloc      = 1'b0;
    set_bit    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    drain_step = 1'b0;
    drain_take = 1'b0;
    drain_done = 1'b0;
    fin_push   = 1'b0;
    emit_req   = 1'b0;
    emit_code  = tlfr_pkg::OUT_DELIVER;
    emit_tag   = job_q.tag;
    emit_seq   = job_q.fseq;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = q_job_i.drop ? B_DROP : B_MATCH;
        end
      end
      B_DROP: begin
        emit_req  = 1'b1;
        emit_code = job_q.code;
        if (can_emit) begin
          state_d = job_end;
        end
      end
      B_MATCH: state_d = B_LOOK;
      B_LOOK: begin
        if (hit_any) begin
          s_d     = hit_idx;
          state_d = B_DEC;
        end else if (free_any) begin
          s_d     = free_idx;
          alloc   = 1'b1;
          state_d = B_DEC;
        end else begin
          emit_req  = 1'b1;
          emit_code = tlfr_pkg::OUT_NO_SLOT;
          if (can_emit) begin
            state_d = job_end;
          end
        end
      end
      B_DEC: begin
        if (job_q.fseq < e_cur) begin
          emit_req  = 1'b1;
          emit_code = tlfr_pkg::OUT_DUP;
          if (can_emit) begin
            state_d = job_end;
          end
        end else if (job_q.fseq == e_cur) begin
          emit_req = 1'b1;
          if (can_emit) begin
            e_d     = e_cur;
            state_d = B_DRAIN;
          end
        end else if (in_win) begin
          if (sfull_q[s_q][k]) begin
            emit_req  = 1'b1;
            emit_code = tlfr_pkg::OUT_DUP;
            if (can_emit) begin
              state_d = job_end;
            end
          end else begin
            set_bit = 1'b1;
            mem_we  = 1'b1;
            state_d = job_end;
          end
        end else begin
          emit_req  = 1'b1;
          emit_code = tlfr_pkg::OUT_BEYOND;
          if (can_emit) begin
            state_d = job_end;
          end
        end
      end
      B_DRAIN: begin
        drain_step = 1'b1;
        e_d        = e_q + 32'd1;
        if (sfull_q[s_q][0]) begin
          drain_take = 1'b1;
          mem_re     = 1'b1;
          state_d    = B_EMIT;
        end else begin
          drain_done = 1'b1;
          state_d    = job_end;
        end
      end
      B_EMIT: begin
        emit_req = 1'b1;
        emit_tag = rdata_q;
        emit_seq = e_q;
        if (can_emit) begin
          state_d = B_DRAIN;
        end
      end
      B_FIN: begin
        if (!pend_v_q) begin
          state_d = B_IDLE;
        end else if (!o_full_i) begin
          fin_push = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // older result goes out when a newer one arrives; the last one gets the flag
  assign o_push_o    = (keep & pend_v_q) | fin_push;
  assign o_res_o     = '{code: pend_q.code, tag: pend_q.tag, stream: pend_q.stream,
                         seq: pend_q.seq, last: fin_push};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      in_use_q <= '0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      for (int i = 0; i < NS; i++) begin
        sfull_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (alloc) begin
        in_use_q[s_d] <= 1'b1;
        sfull_q[s_d]  <= '0;
      end
      if (set_bit) begin
        sfull_q[s_q][k] <= 1'b1;
      end
      if (drain_step) begin
        sfull_q[s_q] <= sfull_q[s_q] >> 1;
      end
      if (keep) begin
        pend_v_q <= 1'b1;
        cnt_q    <= cnt_q + CW'(1);
      end
      if (state_q == B_FIN && state_d == B_IDLE) begin
        pend_v_q <= 1'b0;
        cnt_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    e_q <= e_d;
    if (q_pop_o) begin
      job_q <= q_job_i;
    end
    for (int i = 0; i < NS; i++) begin
      hit_q[i] <= in_use_q[i] && (key_q[i] == job_q.stream);
    end
    if (alloc) begin
      key_q[s_d]  <= job_q.stream;
      exp_q[s_d]  <= 32'd1;
      head_q[s_d] <= '0;
    end
    if (drain_step) begin
      head_q[s_q] <= head_inc(head_q[s_q]);
    end
    if (drain_done) begin
      exp_q[s_q] <= e_d;
    end
    if (keep) begin
      pend_q.code   <= emit_code;
      pend_q.tag    <= emit_tag;
      pend_q.stream <= job_q.stream;
      pend_q.seq    <= emit_seq;
      pend_q.last   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_wa] <= job_q.tag;
    end
    if (mem_re && drain_take) begin
      rdata_q <= tag_mem[mem_ra];
    end
  end

endmodule

@@ hw/rtl/two_level_frame_reorder_top.sv @@
// path of a frame: header level, job queue, stream-level sequencer, result queue;
//   the sequencer takes one job at a time: a header-level drop is only reported, other
//   frames pass table compare, lookup and window decision before they are reported;
//   frames released from a stream window or from the header window go out one by one
// reset: asynchronous, clears both windows and the stream table at once, no clearing pass
// ----------------------------------------------------------------------------
// two_level_frame_reorder_top
// two-level sequence reorder buffer: header order first, then per-stream order
// ----------------------------------------------------------------------------
module two_level_frame_reorder_top #(
  parameter int HEADER_WINDOW = 4,
  parameter int STREAM_WINDOW = 8,
  parameter int STREAM_SLOTS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  frame_type_i,
  input  logic [31:0] header_seq_i,
  input  logic [31:0] frame_seq_i,
  input  logic [30:0] stream_ident_i,
  input  logic [15:0] frame_tag_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  outcome_o,
  output logic [15:0] out_tag_o,
  output logic [30:0] out_stream_o,
  output logic [31:0] out_seq_o,
  output logic        last_o
);

  localparam int JOB_W = $bits(tlfr_pkg::job_t);
  localparam int RES_W = $bits(tlfr_pkg::res_t);

  // front to back job queue
  logic           jq_push, jq_full, jq_pop, jq_empty;
  tlfr_pkg::job_t jq_wdata, jq_rdata;
  logic [JOB_W-1:0] jq_rvec;

  // back to result queue
  logic           rq_push, rq_full;
  tlfr_pkg::res_t rq_wdata, rq_rdata;
  logic [RES_W-1:0] rq_rvec;

  // header level: classifies each transfer and releases header frames in order
  tlfr_front #(
    .HEADER_WINDOW (HEADER_WINDOW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .frame_type_i   (frame_type_i),
    .header_seq_i   (header_seq_i),
    .frame_seq_i    (frame_seq_i),
    .stream_ident_i (stream_ident_i),
    .frame_tag_i    (frame_tag_i),
    .q_push_o       (jq_push),
    .q_job_o        (jq_wdata),
    .q_full_i       (jq_full)
  );

  // short decoupling queue so a header cascade and stream drains overlap
  tlfr_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (4)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .data_i  (jq_wdata),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .data_o  (jq_rvec),
    .empty_o (jq_empty)
  );

  assign jq_rdata = tlfr_pkg::job_t'(jq_rvec);

  // stream level: lookup, window insert, in-order release, result codes
  tlfr_back #(
    .STREAM_WINDOW (STREAM_WINDOW),
    .STREAM_SLOTS  (STREAM_SLOTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (jq_empty),
    .q_job_i   (jq_rdata),
    .q_pop_o   (jq_pop),
    .o_full_i  (rq_full),
    .o_push_o  (rq_push),
    .o_res_o   (rq_wdata)
  );

  // result queue parts the back end from the consumer
  tlfr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (4)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_rvec),
    .empty_o (empty)
  );

  assign rq_rdata     = tlfr_pkg::res_t'(rq_rvec);
  assign outcome_o    = rq_rdata.code;
  assign out_tag_o    = rq_rdata.tag;
  assign out_stream_o = rq_rdata.stream;
  assign out_seq_o    = rq_rdata.seq;
  assign last_o       = rq_rdata.last;

endmodule

@@ hw/rtl/tlfr_checker.sv @@
// ----------------------------------------------------------------------------
// tlfr_checker
// port-level checks of the two-level frame reorder block
// ----------------------------------------------------------------------------
module tlfr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop
);

  // reset leaves both sides open and nothing waiting
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("block not idle after reset");

  // the input side only fills up through a transfer in
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an input transfer");

  // a waiting result is not withdrawn
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

endmodule

bind two_level_frame_reorder_top tlfr_checker u_tlfr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop)
);
